// ===== sv/ffsa_pkg.sv =====
// ffsa_pkg: shared constants, codes and types for the first-fit segment allocator.
// No dependencies.
package ffsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int OFFSET_BITS_DEF  = 32;
    localparam int PORT_BITS        = 32;
    localparam logic [31:0] BLOCK_SIZE_RST = 32'd65536;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADSIZE = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Row-wide command, identical for every cell.
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_INIT   = 3'd1,
        CMD_REMOVE = 3'd2,  // cells >= pos take the right neighbor
        CMD_INSERT = 3'd3,  // cells > pos take the left neighbor, pos takes new
        CMD_WRITE  = 3'd4,  // cell pos takes new offset/size
        CMD_MERGE  = 3'd5   // cell pos takes new, cells > pos take the right neighbor
    } cmd_e_t;

endpackage

// ===== sv/ffsa_cell.sv =====
// ffsa_cell: one free-table entry with local compare flags.
// Depends on ffsa_pkg.
module ffsa_cell #(
    parameter int OB = ffsa_pkg::OFFSET_BITS_DEF,
    parameter logic [OB-1:0] RST_SIZE = '0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ffsa_pkg::cmd_e_t cmd,
    input  logic          is_pos,      // this cell is the target
    input  logic          after_pos,   // this cell lies above the target
    input  logic          is_first,
    input  logic [OB-1:0] init_size,
    input  logic [OB-1:0] new_off,
    input  logic [OB-1:0] new_size,
    input  logic [OB-1:0] left_off,
    input  logic [OB-1:0] left_size,
    input  logic [OB-1:0] right_off,
    input  logic [OB-1:0] right_size,
    input  logic [OB-1:0] req,
    input  logic [OB-1:0] fo,
    output logic [OB-1:0] off,
    output logic [OB-1:0] size,
    output logic          fits,        // size >= req
    output logic          le_fo        // off <= fo
);
    logic [OB-1:0] off_reg, off_next, size_reg, size_next;

    always_comb
    begin
        off_next  = off_reg;
        size_next = size_reg;
        unique case (cmd)
            ffsa_pkg::CMD_INIT:
            begin
                off_next  = '0;
                size_next = is_first ? init_size : '0;
            end
            ffsa_pkg::CMD_REMOVE:
            begin
                if (is_pos || after_pos)
                begin
                    off_next  = right_off;
                    size_next = right_size;
                end
            end
            ffsa_pkg::CMD_INSERT:
            begin
                if (is_pos)
                begin
                    off_next  = new_off;
                    size_next = new_size;
                end
                else if (after_pos)
                begin
                    off_next  = left_off;
                    size_next = left_size;
                end
            end
            ffsa_pkg::CMD_WRITE:
            begin
                if (is_pos)
                begin
                    off_next  = new_off;
                    size_next = new_size;
                end
            end
            ffsa_pkg::CMD_MERGE:
            begin
                if (is_pos)
                begin
                    off_next  = new_off;
                    size_next = new_size;
                end
                else if (after_pos)
                begin
                    off_next  = right_off;
                    size_next = right_size;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= '0;
            size_reg <= RST_SIZE;
        end
        else
        begin
            off_reg  <= off_next;
            size_reg <= size_next;
        end
    end

    assign off   = off_reg;
    assign size  = size_reg;
    assign fits  = size_reg >= req;
    assign le_fo = off_reg <= fo;
endmodule

// ===== sv/first_fit_segment_allocator.sv =====
// first_fit_segment_allocator: top level, sequencer plus a row of ffsa_cell entries.
// Depends on ffsa_pkg and ffsa_cell.
//
// Free-list allocator. The free table is a row of MAX_SEGMENTS cells kept in
// offset order; every cell compares its own entry against the request in
// parallel, a priority pick finds the first fitting entry (allocate) or the
// first entry above the freed offset (free), and the table shifts one place
// left or right to drop or insert an entry. A request walks three states
// after the edge that accepts it: cell compare and pick, neighbor check and
// arithmetic, table update; the result then sits in the output register. The
// next request is accepted at the edge that takes the result, so the block
// does not take a new request before the last one is through; while the
// result is stalled the input is stalled too. Writing block_size reloads the
// table with one segment (0, block_size); write it only while the block is
// idle. Coalesced sizes saturate at all ones; offsets of carved remainders
// wrap.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int OFFSET_BITS  = ffsa_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] req_size,
    input  logic [31:0] free_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] grant_offset,
    output logic [31:0] grant_size
);
    localparam int OB = OFFSET_BITS;
    localparam int N  = MAX_SEGMENTS;
    localparam int PB = $clog2(N + 1);  // position incl. N
    localparam int IB = $clog2(N);
    localparam int PW = ffsa_pkg::PORT_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PICK = 4'b0010,
        S_CALC = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [OB-1:0] bsize_reg;
    logic          op_reg;
    logic [OB-1:0] req_reg, fo_reg;
    logic [PB-1:0] count_reg, count_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic          found_reg, found_next;
    // picked neighbors
    logic [OB-1:0] po_reg, ps_reg, no_reg, ns_reg;
    logic [OB-1:0] po_next, ps_next, no_next, ns_next;
    // decided update
    ffsa_pkg::cmd_e_t cmd_reg, cmd_next, cmd;
    logic [PB-1:0] upos_reg, upos_next;
    logic [OB-1:0] uoff_reg, uoff_next, usize_reg, usize_next;
    logic          cdec_reg, cdec_next, cinc_reg, cinc_next;
    // output register
    logic          ovalid_reg;
    logic [1:0]    ost_reg, ost_next;
    logic [OB-1:0] ooff_reg, ooff_next, osz_reg, osz_next;

    logic [OB-1:0] c_off [N];
    logic [OB-1:0] c_size [N];
    logic [N-1:0]  c_fits, c_le;

    logic cfg_fire, in_fire;
    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_fire  = cfg_valid && cfg_ready;
    // a request may enter in the cycle the waiting result leaves
    assign in_stall  = (state_reg != S_IDLE) || (ovalid_reg && out_stall) || cfg_valid;
    assign in_fire   = in_valid && !in_stall;

    // Cell row
    assign cmd = cfg_fire ? ffsa_pkg::CMD_INIT :
                 (state_reg == S_UPD) ? cmd_reg : ffsa_pkg::CMD_HOLD;

    logic [OB-1:0] init_size;
    assign init_size = OB'(cfg_data);

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic [OB-1:0] lo, ls, ro, rs;
            if (g == 0)
            begin : g_l0
                assign lo = '0;
                assign ls = '0;
            end
            else
            begin : g_l
                assign lo = c_off[g-1];
                assign ls = c_size[g-1];
            end
            if (g == N - 1)
            begin : g_rn
                assign ro = '0;
                assign rs = '0;
            end
            else
            begin : g_r
                assign ro = c_off[g+1];
                assign rs = c_size[g+1];
            end
            ffsa_cell #(
                .OB       (OB),
                .RST_SIZE ((g == 0) ? OB'(ffsa_pkg::BLOCK_SIZE_RST) : OB'(0))
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .is_pos     (upos_reg == PB'(g)),
                .after_pos  (PB'(g) > upos_reg),
                .is_first   (g == 0),
                .init_size  (init_size),
                .new_off    (uoff_reg),
                .new_size   (usize_reg),
                .left_off   (lo),
                .left_size  (ls),
                .right_off  (ro),
                .right_size (rs),
                .req        (req_reg),
                .fo         (fo_reg),
                .off        (c_off[g]),
                .size       (c_size[g]),
                .fits       (c_fits[g]),
                .le_fo      (c_le[g])
            );
        end
    endgenerate

    // Pick: first fitting live entry, or first live entry with off > fo
    // (count when there is none). Carved offsets may break the order, so the
    // insertion point is the first entry above fo, not a count.
    logic [PB-1:0] pick_first, pick_ins;
    logic          pick_found;
    always_comb
    begin
        pick_first = '0;
        pick_found = 1'b0;
        pick_ins   = count_reg;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (PB'(i) < count_reg && c_fits[i])
            begin
                pick_first = PB'(i);
                pick_found = 1'b1;
            end
            if (PB'(i) < count_reg && !c_le[i])
                pick_ins = PB'(i);
        end
    end

    // Calc-stage arithmetic
    logic [OB:0]   prev_end, next_end, s1, s2;
    logic [OB-1:0] sat1, sat2;
    logic          prev_adj, next_adj, p_live, n_live;
    always_comb
    begin
        p_live   = pos_reg != '0;
        n_live   = pos_reg < count_reg;
        prev_end = {1'b0, po_reg} + {1'b0, ps_reg};
        next_end = {1'b0, fo_reg} + {1'b0, req_reg};
        prev_adj = p_live && (prev_end == {1'b0, fo_reg});
        next_adj = n_live && (next_end == {1'b0, no_reg});
        s1   = {1'b0, (prev_adj ? ps_reg : {OB{1'b0}})} + {1'b0, req_reg};
        sat1 = s1[OB] ? '1 : s1[OB-1:0];
        s2   = {1'b0, sat1} + {1'b0, (next_adj ? ns_reg : {OB{1'b0}})};
        sat2 = s2[OB] ? '1 : s2[OB-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        cmd_next   = cmd_reg;
        upos_next  = upos_reg;
        uoff_next  = uoff_reg;
        usize_next = usize_reg;
        cdec_next  = cdec_reg;
        cinc_next  = cinc_reg;
        ost_next   = ost_reg;
        ooff_next  = ooff_reg;
        osz_next   = osz_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                    count_next = PB'(1);
                else if (in_fire)
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                pos_next   = (op_reg == ffsa_pkg::OP_ALLOC) ? pick_first : pick_ins;
                found_next = pick_found;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd_next  = ffsa_pkg::CMD_HOLD;
                cdec_next = 1'b0;
                cinc_next = 1'b0;
                ooff_next = '0;
                osz_next  = '0;
                ost_next  = ffsa_pkg::ST_OK;
                upos_next = pos_reg;
                if (op_reg == ffsa_pkg::OP_ALLOC)
                begin
                    if (req_reg == '0 || req_reg > bsize_reg)
                        ost_next = ffsa_pkg::ST_BADSIZE;
                    else if (!found_reg)
                        ost_next = ffsa_pkg::ST_NOFIT;
                    else
                    begin
                        ooff_next = no_reg;
                        osz_next  = req_reg;
                        if (ns_reg == req_reg)
                        begin
                            cmd_next  = ffsa_pkg::CMD_REMOVE;
                            cdec_next = 1'b1;
                        end
                        else
                        begin
                            cmd_next   = ffsa_pkg::CMD_WRITE;
                            uoff_next  = no_reg + req_reg;
                            usize_next = ns_reg - req_reg;
                        end
                    end
                end
                else
                begin
                    if (req_reg == '0)
                        ost_next = ffsa_pkg::ST_BADSIZE;
                    else if (prev_adj && next_adj)
                    begin
                        // predecessor takes the merged entry, successor drops out
                        cmd_next   = ffsa_pkg::CMD_MERGE;
                        upos_next  = pos_reg - PB'(1);
                        cdec_next  = 1'b1;
                        uoff_next  = po_reg;
                        usize_next = sat2;
                    end
                    else if (prev_adj)
                    begin
                        cmd_next   = ffsa_pkg::CMD_WRITE;
                        upos_next  = pos_reg - PB'(1);
                        uoff_next  = po_reg;
                        usize_next = sat1;
                    end
                    else if (next_adj)
                    begin
                        cmd_next   = ffsa_pkg::CMD_WRITE;
                        uoff_next  = fo_reg;
                        usize_next = sat2;
                    end
                    else if (count_reg >= PB'(N))
                        ost_next = ffsa_pkg::ST_FULL;
                    else
                    begin
                        cmd_next   = ffsa_pkg::CMD_INSERT;
                        cinc_next  = 1'b1;
                        uoff_next  = fo_reg;
                        usize_next = req_reg;
                    end
                end
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (cdec_reg)
                    count_next = count_reg - PB'(1);
                else if (cinc_reg)
                    count_next = count_reg + PB'(1);
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Neighbor capture in S_PICK, straight off the row by the picked index.
    logic [IB-1:0] ix_prev, ix_cur;
    always_comb
    begin
        logic [PB-1:0] p;
        p = (op_reg == ffsa_pkg::OP_ALLOC) ? pick_first : pick_ins;
        ix_cur  = (p >= PB'(N)) ? IB'(N - 1) : p[IB-1:0];
        ix_prev = (p == '0) ? '0 : IB'(p - PB'(1));
        po_next = c_off[ix_prev];
        ps_next = c_size[ix_prev];
        no_next = c_off[ix_cur];
        ns_next = c_size[ix_cur];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= PB'(1);
            bsize_reg  <= OB'(ffsa_pkg::BLOCK_SIZE_RST);
            ovalid_reg <= 1'b0;
            cmd_reg    <= ffsa_pkg::CMD_HOLD;
            cdec_reg   <= 1'b0;
            cinc_reg   <= 1'b0;
            found_reg  <= 1'b0;
            pos_reg    <= '0;
            upos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
            cmd_reg   <= cmd_next;
            upos_reg  <= upos_next;
            cdec_reg  <= cdec_next;
            cinc_reg  <= cinc_next;
            if (cfg_fire)
                bsize_reg <= OB'(cfg_data);
            if (state_reg == S_UPD)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= opcode;
            req_reg <= OB'(req_size);
            fo_reg  <= OB'(free_offset);
        end
        if (state_reg == S_PICK)
        begin
            po_reg <= po_next;
            ps_reg <= ps_next;
            no_reg <= no_next;
            ns_reg <= ns_next;
        end
        uoff_reg  <= uoff_next;
        usize_reg <= usize_next;
        ost_reg   <= ost_next;
        ooff_reg  <= ooff_next;
        osz_reg   <= osz_next;
    end

    assign out_valid    = ovalid_reg;
    assign status       = ost_reg;
    assign grant_offset = PW'(ooff_reg);
    assign grant_size   = PW'(osz_reg);
endmodule
